FILE: rtl/core/echo_range_median_scaler_top_macros.svh
// Assertion helpers shared by the core modules.
// Each one expects signals named clk and rst_n in the using module.
`ifndef ECHO_RANGE_MEDIAN_SCALER_TOP_MACROS_SVH
`define ECHO_RANGE_MEDIAN_SCALER_TOP_MACROS_SVH

// Same-cycle implication, checked once reset is released
`define ERS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked once reset is released
`define ERS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ers_pkg.sv
package ers_pkg;

  // Field widths
  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_CFG_W = 5;
  localparam int MODE_W    = 2;

  // Arithmetic widths of the mapping unit
  localparam int DIFF_W  = DATA_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int TOTAL_W = PROD_W + 1;
  localparam int QUOT_W  = DATA_W;

  // Default store depth
  localparam int MAX_DEPTH_DEF = 16;

  // Mode bit positions
  localparam int MODE_BIT_ILV = 0;
  localparam int MODE_BIT_INV = 1;

  // Register reset values
  localparam logic [CNT_CFG_W-1:0]  RST_SAMPLE_COUNT = CNT_CFG_W'(1);
  localparam logic [MODE_W-1:0]     RST_MODE         = '0;
  localparam logic [DATA_W-1:0]     RST_READING_MIN  = DATA_W'(200);
  localparam logic [DATA_W-1:0]     RST_READING_MAX  = DATA_W'(2500);
  localparam logic signed [DATA_W-1:0] RST_VALUE_MIN = DATA_W'(0);
  localparam logic signed [DATA_W-1:0] RST_VALUE_MAX = DATA_W'(100);
  localparam logic signed [DATA_W-1:0] RST_BAND_LOW  = DATA_W'(0);
  localparam logic signed [DATA_W-1:0] RST_BAND_HIGH = DATA_W'(100);
  localparam logic signed [DATA_W-1:0] RST_LAST_VALUE = '1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT = 3'd0,
    REG_MODE         = 3'd1,
    REG_READING_MIN  = 3'd2,
    REG_READING_MAX  = 3'd3,
    REG_VALUE_MIN    = 3'd4,
    REG_VALUE_MAX    = 3'd5,
    REG_BAND_LOW     = 3'd6,
    REG_BAND_HIGH    = 3'd7
  } reg_idx_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [CNT_CFG_W-1:0]      sample_count;
    logic [MODE_W-1:0]         mode;
    logic [DATA_W-1:0]         reading_min;
    logic [DATA_W-1:0]         reading_max;
    logic signed [DATA_W-1:0]  value_min;
    logic signed [DATA_W-1:0]  value_max;
    logic signed [DATA_W-1:0]  band_low;
    logic signed [DATA_W-1:0]  band_high;
  } cfg_t;

  // Completion report of a worker unit
  typedef struct packed {
    logic                      done;
    logic signed [DATA_W-1:0]  value;
  } unit_rsp_t;

endpackage

FILE: rtl/core/ers_in_if.sv
interface ers_in_if;
  logic                        valid;
  logic                        ready;
  logic [ers_pkg::DATA_W-1:0]  echo_width;

  modport source (output valid, output echo_width, input ready);
  modport sink (input valid, input echo_width, output ready);
endinterface

FILE: rtl/core/ers_out_if.sv
interface ers_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ers_pkg::DATA_W-1:0]  scaled_value;
  logic                               value_changed;

  modport source (output valid, output scaled_value, output value_changed, input ready);
  modport sink (input valid, input scaled_value, input value_changed, output ready);
endinterface

FILE: rtl/core/ers_cfg_if.sv
interface ers_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ers_pkg::CFG_IDX_W-1:0]  index;
  logic [ers_pkg::DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ers_ram.sv
module ers_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/ers_mapper.sv
module ers_mapper (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ers_pkg::DATA_W-1:0]  echo_width,
  input  ers_pkg::cfg_t               cfg,
  output ers_pkg::unit_rsp_t          rsp
);
  import ers_pkg::*;

  localparam int DIV_CNT_W = $clog2(QUOT_W);

  typedef enum logic [7:0] {
    M_IDLE = 8'b0000_0001,
    M_PREP = 8'b0000_0010,
    M_MULN = 8'b0000_0100,
    M_MULB = 8'b0000_1000,
    M_SUM  = 8'b0001_0000,
    M_ABS  = 8'b0010_0000,
    M_DIV  = 8'b0100_0000,
    M_SIGN = 8'b1000_0000
  } map_state_t;

  map_state_t state_r, state_nxt;

  logic [DATA_W-1:0]         echo_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [DIFF_W-1:0]  dv_r;
  logic [DATA_W-1:0]         den_r;
  logic                      flip_r;
  logic signed [PROD_W-1:0]  num_r;
  logic signed [PROD_W-1:0]  bd_r;
  logic signed [TOTAL_W-1:0] total_r;
  logic                      neg_r;
  logic [DATA_W-1:0]         rem_r;
  logic [QUOT_W-1:0]         sh_r;
  logic [DIV_CNT_W-1:0]      cnt_r;
  logic signed [DATA_W-1:0]  res_r;
  logic                      done_r;

  logic [DATA_W-1:0]         w_eff;
  logic [DATA_W-1:0]         clamp_w;
  logic signed [DIFF_W-1:0]  diff_c;
  logic signed [DIFF_W-1:0]  den_c;
  logic signed [DIFF_W-1:0]  den_neg_c;
  logic signed [DIFF_W-1:0]  dv_c;
  logic                      inv;
  logic signed [DATA_W-1:0]  base;
  logic signed [DIFF_W-1:0]  mul_a;
  logic signed [DIFF_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [TOTAL_W-1:0] total_c;
  logic [TOTAL_W-1:0]        mag_c;
  logic [DATA_W+1:0]         sub_c;
  logic                      ge_c;

  assign inv  = cfg.mode[MODE_BIT_INV];
  assign base = inv ? cfg.value_max : cfg.value_min;

  // Substitute timeout, clamp to the reading range
  always_comb begin
    w_eff = (echo_r == '0) ? cfg.reading_max : echo_r;
    if (w_eff < cfg.reading_min) begin
      clamp_w = cfg.reading_min;
    end else if (w_eff > cfg.reading_max) begin
      clamp_w = cfg.reading_max;
    end else begin
      clamp_w = w_eff;
    end
  end

  assign diff_c    = $signed({1'b0, clamp_w}) - $signed({1'b0, cfg.reading_min});
  assign den_c     = $signed({1'b0, cfg.reading_max}) - $signed({1'b0, cfg.reading_min});
  assign den_neg_c = -den_c;
  assign dv_c      = $signed({cfg.value_max[DATA_W-1], cfg.value_max})
                   - $signed({cfg.value_min[DATA_W-1], cfg.value_min});

  // Shared multiplier: range product first, then base times span
  always_comb begin
    if (state_r == M_MULB) begin
      mul_a = $signed({base[DATA_W-1], base});
      mul_b = $signed({1'b0, den_r});
    end else begin
      mul_a = diff_r;
      mul_b = dv_r;
    end
  end

  assign mul_p = mul_a * mul_b;

  // Combine products, fold sign of the span into the operation
  assign total_c = flip_r
    ? ($signed({bd_r[PROD_W-1], bd_r}) - $signed({num_r[PROD_W-1], num_r}))
    : ($signed({bd_r[PROD_W-1], bd_r}) + $signed({num_r[PROD_W-1], num_r}));

  assign mag_c = total_r[TOTAL_W-1] ? TOTAL_W'(-total_r) : TOTAL_W'(total_r);

  // One restoring division step
  assign sub_c = {1'b0, rem_r, sh_r[QUOT_W-1]} - {2'b00, den_r};
  assign ge_c  = !sub_c[DATA_W+1];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      M_IDLE: if (start) state_nxt = M_PREP;
      M_PREP: state_nxt = (den_c == '0) ? M_IDLE : M_MULN;
      M_MULN: state_nxt = M_MULB;
      M_MULB: state_nxt = M_SUM;
      M_SUM:  state_nxt = M_ABS;
      M_ABS:  state_nxt = M_DIV;
      M_DIV:  if (cnt_r == DIV_CNT_W'(QUOT_W - 1)) state_nxt = M_SIGN;
      M_SIGN: state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= ((state_r == M_PREP) && (den_c == '0)) || (state_r == M_SIGN);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      M_IDLE: begin
        if (start) echo_r <= echo_width;
      end
      M_PREP: begin
        diff_r <= diff_c;
        dv_r   <= dv_c;
        den_r  <= den_c[DIFF_W-1] ? den_neg_c[DATA_W-1:0] : den_c[DATA_W-1:0];
        flip_r <= inv ^ den_c[DIFF_W-1];
        res_r  <= base;
      end
      M_MULN: num_r <= mul_p;
      M_MULB: bd_r  <= mul_p;
      M_SUM:  total_r <= total_c;
      M_ABS: begin
        neg_r <= total_r[TOTAL_W-1];
        rem_r <= mag_c[QUOT_W+DATA_W-1:QUOT_W];
        sh_r  <= mag_c[QUOT_W-1:0];
        cnt_r <= '0;
      end
      M_DIV: begin
        rem_r <= ge_c ? sub_c[DATA_W-1:0] : {rem_r[DATA_W-2:0], sh_r[QUOT_W-1]};
        sh_r  <= {sh_r[QUOT_W-2:0], ge_c};
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
      M_SIGN: res_r <= neg_r ? $signed(-sh_r) : $signed(sh_r);
      default: ;
    endcase
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

FILE: rtl/core/ers_median.sv
`include "echo_range_median_scaler_top_macros.svh"

module ers_median #(
  parameter int MAX_DEPTH = ers_pkg::MAX_DEPTH_DEF,
  localparam int CNT_W  = $clog2(MAX_DEPTH + 1),
  localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [CNT_W-1:0]            count,
  output logic [ADDR_W-1:0]           rd_addr,
  input  logic [ers_pkg::DATA_W-1:0]  rd_data,
  output ers_pkg::unit_rsp_t          rsp
);
  import ers_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CAND  = 5'b00010,
    S_FETCH = 5'b00100,
    S_SCAN  = 5'b01000,
    S_CHECK = 5'b10000
  } med_state_t;

  med_state_t state_r, state_nxt;

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          i_r;
  logic [CNT_W-1:0]          j_r;
  logic [CNT_W-1:0]          less_r;
  logic [CNT_W-1:0]          eq_r;
  logic signed [DATA_W-1:0]  cand_r;
  logic signed [DATA_W-1:0]  res_r;
  logic                      done_r;

  logic [CNT_W-1:0]          k_c;
  logic [CNT_W:0]            upper_c;
  logic                      hit_c;
  logic                      lt_c;
  logic                      eq_c;

  // Rank test for the upper median
  assign k_c     = count_r >> 1;
  assign upper_c = {1'b0, less_r} + {1'b0, eq_r};
  assign hit_c   = (less_r <= k_c) && ({1'b0, k_c} < upper_c);
  assign lt_c    = $signed(rd_data) < cand_r;
  assign eq_c    = $signed(rd_data) == cand_r;

  // Read address per step
  always_comb begin
    unique case (state_r)
      S_CAND:  rd_addr = i_r[ADDR_W-1:0];
      S_SCAN:  rd_addr = j_r[ADDR_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  // Sequencer: pick a candidate, count smaller and equal entries, test rank
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_CAND;
      S_CAND:  state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_SCAN;
      S_SCAN:  if (j_r == count_r) state_nxt = S_CHECK;
      S_CHECK: state_nxt = hit_c ? S_IDLE : S_CAND;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == S_CHECK) && hit_c;
    end
  end

  // Counters and candidate
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          count_r <= count;
          i_r     <= '0;
        end
      end
      S_FETCH: begin
        cand_r <= $signed(rd_data);
        less_r <= '0;
        eq_r   <= '0;
        j_r    <= CNT_W'(1);
      end
      S_SCAN: begin
        less_r <= less_r + CNT_W'(lt_c);
        eq_r   <= eq_r + CNT_W'(eq_c);
        if (j_r != count_r) j_r <= j_r + CNT_W'(1);
      end
      S_CHECK: begin
        res_r <= cand_r;
        i_r   <= i_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

  `ERS_ASSERT_IMP(a_start_idle, start, state_r == S_IDLE, "median start while busy")
  `ERS_ASSERT_IMP(a_rank_bound, state_r == S_CHECK, upper_c <= {1'b0, count_r}, "rank count overrun")
  `ERS_ASSERT_IMP(a_scan_index, state_r == S_SCAN, (j_r != '0) && (j_r <= count_r), "scan index out of run")
  `ERS_ASSERT_IMP(a_cand_bound, state_r == S_CAND, i_r < count_r, "no candidate met the median rank")
  `ERS_ASSERT_NXT(a_done_pulse, done_r, !done_r, "median done held longer than one cycle")

endmodule

FILE: rtl/core/echo_range_median_scaler_top.sv
// A request is mapped first; when one reading makes a result, that result goes straight to the output register.
// A median over a run of m readings adds a rank selection before the result.
// A new request is taken only when idle; the mapper uses a shared multiply and a 16-step divide.
// The next request is taken while a finished result still waits in the output register.
// Reset (rst_n low, synchronous): registers return to defaults, sample count clears,
// previous value becomes -1; the sample store keeps its contents.
`include "echo_range_median_scaler_top_macros.svh"

module echo_range_median_scaler_top #(
  parameter int MAX_DEPTH = ers_pkg::MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ers_in_if.sink      in_chan,
  ers_out_if.source   out_chan,
  ers_cfg_if.sink     cfg_chan
);
  import ers_pkg::*;

  localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_MAP  = 4'b0010,
    T_MED  = 4'b0100,
    T_FIN  = 4'b1000
  } top_state_t;

  top_state_t state_r, state_nxt;

  cfg_t                      cfg_r;
  logic [CNT_W-1:0]          held_r, held_nxt;
  logic signed [DATA_W-1:0]  last_r;
  logic signed [DATA_W-1:0]  res_r, res_nxt;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_value_r;
  logic                      out_changed_r;

  logic                      accept;
  logic                      out_free;
  logic                      out_load;
  logic                      changed_c;
  logic [CNT_W-1:0]          n_eff;
  logic [CNT_W-1:0]          h0;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [DATA_W-1:0]         ram_rdata;
  logic                      med_start;
  logic [CNT_W-1:0]          med_count;
  unit_rsp_t                 map_rsp;
  unit_rsp_t                 med_rsp;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == T_IDLE);
  assign cfg_chan.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count <= RST_SAMPLE_COUNT;
      cfg_r.mode         <= RST_MODE;
      cfg_r.reading_min  <= RST_READING_MIN;
      cfg_r.reading_max  <= RST_READING_MAX;
      cfg_r.value_min    <= RST_VALUE_MIN;
      cfg_r.value_max    <= RST_VALUE_MAX;
      cfg_r.band_low     <= RST_BAND_LOW;
      cfg_r.band_high    <= RST_BAND_HIGH;
    end else if (cfg_chan.valid) begin
      unique case (reg_idx_t'(cfg_chan.index))
        REG_SAMPLE_COUNT: cfg_r.sample_count <= cfg_chan.data[CNT_CFG_W-1:0];
        REG_MODE:         cfg_r.mode         <= cfg_chan.data[MODE_W-1:0];
        REG_READING_MIN:  cfg_r.reading_min  <= cfg_chan.data;
        REG_READING_MAX:  cfg_r.reading_max  <= cfg_chan.data;
        REG_VALUE_MIN:    cfg_r.value_min    <= $signed(cfg_chan.data);
        REG_VALUE_MAX:    cfg_r.value_max    <= $signed(cfg_chan.data);
        REG_BAND_LOW:     cfg_r.band_low     <= $signed(cfg_chan.data);
        REG_BAND_HIGH:    cfg_r.band_high    <= $signed(cfg_chan.data);
        default: ;
      endcase
    end
  end

  // Run length, capped at the store depth
  assign n_eff = (int'(cfg_r.sample_count) > MAX_DEPTH)
               ? CNT_W'(MAX_DEPTH) : CNT_W'(cfg_r.sample_count);
  assign h0    = (held_r >= n_eff) ? '0 : held_r;

  // Sequencer: map the reading, then store it, take a median or pass it on
  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = h0[ADDR_W-1:0];
    med_start = 1'b0;
    med_count = n_eff;
    unique case (state_r)
      T_IDLE: begin
        if (accept) state_nxt = T_MAP;
      end
      T_MAP: begin
        if (map_rsp.done) begin
          if (n_eff <= CNT_W'(1)) begin
            res_nxt   = map_rsp.value;
            state_nxt = T_FIN;
          end else if (cfg_r.mode[MODE_BIT_ILV]) begin
            if (held_r < n_eff) begin
              ram_we    = 1'b1;
              ram_waddr = held_r[ADDR_W-1:0];
              held_nxt  = held_r + CNT_W'(1);
              state_nxt = T_IDLE;
            end else begin
              med_start = 1'b1;
              med_count = held_r;
              held_nxt  = '0;
              state_nxt = T_MED;
            end
          end else begin
            ram_we = 1'b1;
            if ((h0 + CNT_W'(1)) < n_eff) begin
              held_nxt  = h0 + CNT_W'(1);
              state_nxt = T_IDLE;
            end else begin
              med_start = 1'b1;
              held_nxt  = '0;
              state_nxt = T_MED;
            end
          end
        end
      end
      T_MED: begin
        if (med_rsp.done) begin
          res_nxt   = med_rsp.value;
          state_nxt = T_FIN;
        end
      end
      T_FIN: begin
        if (out_free) state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  // Output register parts the result side from the request side
  assign out_free  = !out_valid_r || out_chan.ready;
  assign out_load  = (state_r == T_FIN) && out_free;
  assign changed_c = (res_r != last_r) && (res_r >= cfg_r.band_low)
                   && (res_r <= cfg_r.band_high);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      held_r      <= '0;
      last_r      <= RST_LAST_VALUE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      if (out_load) begin
        last_r      <= res_r;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (out_load) begin
      out_value_r   <= res_r;
      out_changed_r <= changed_c;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.scaled_value  = out_value_r;
  assign out_chan.value_changed = out_changed_r;

  ers_mapper u_mapper (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .echo_width (in_chan.echo_width),
    .cfg        (cfg_r),
    .rsp        (map_rsp)
  );

  ers_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (map_rsp.value),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  ers_median #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_median (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (med_start),
    .count   (med_count),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata),
    .rsp     (med_rsp)
  );

  `ERS_ASSERT_IMP(a_held_bound, 1'b1, held_r <= CNT_W'(MAX_DEPTH), "sample count above store depth")
  `ERS_ASSERT_IMP(a_map_done, map_rsp.done, state_r == T_MAP, "mapping finished outside its wait")
  `ERS_ASSERT_IMP(a_med_done, med_rsp.done, state_r == T_MED, "median finished outside its wait")
  `ERS_ASSERT_IMP(a_med_count, med_start, (med_count > CNT_W'(1)) && (med_count <= CNT_W'(MAX_DEPTH)), "median run length out of range")
  `ERS_ASSERT_NXT(a_busy_after, accept, !in_chan.ready, "request taken while still working")

endmodule

FILE: bench/tb.sv
module tb;
  import ers_pkg::*;

  localparam int ITEM_TARGET   = 1950;
  localparam int CALM_TAIL     = 250;
  // time for a request that only fills the store to finish
  localparam int SETTLE_CYCLES = 80;
  // time for a 16-deep median to finish its rank selection
  localparam int DRAIN_CYCLES  = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int DEPTH         = MAX_DEPTH_DEF;
  localparam int MAX_PRINTS    = 200;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     changed;
  } scaled_res_t;

  typedef enum logic {ROW_ECHO, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    reg_idx_t                 idx;
    logic [DATA_W-1:0]        data;
    logic                     typed;
    logic signed [DATA_W-1:0] exp_value;
    logic                     exp_changed;
  } directed_row_t;

  // Directed rows: typed rows carry their result, the rest use the predictor
  localparam directed_row_t DIRECTED [40] = '{
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd0,     1'b1, 16'sd100,  1'b1}, // timeout
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd200,   1'b1, 16'sd0,    1'b1},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd2500,  1'b1, 16'sd100,  1'b1},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd65535, 1'b1, 16'sd100,  1'b0}, // clamp high
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd1,     1'b1, 16'sd0,    1'b1}, // clamp low
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd1350,  1'b1, 16'sd50,   1'b1},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd1350,  1'b1, 16'sd50,   1'b0}, // no change
    '{ROW_REG,  REG_MODE,         16'd2,     1'b0, 16'sd0,    1'b0}, // inverted
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd200,   1'b1, 16'sd100,  1'b1},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd0,     1'b1, 16'sd0,    1'b1},
    '{ROW_REG,  REG_READING_MAX,  16'd200,   1'b0, 16'sd0,    1'b0}, // empty range
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd5000,  1'b1, 16'sd100,  1'b1},
    '{ROW_REG,  REG_MODE,         16'd0,     1'b0, 16'sd0,    1'b0},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd7,     1'b1, 16'sd0,    1'b1},
    '{ROW_REG,  REG_READING_MIN,  16'd2500,  1'b0, 16'sd0,    1'b0}, // swapped range
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd3000,  1'b0, 16'sd0,    1'b0},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd1000,  1'b0, 16'sd0,    1'b0},
    '{ROW_REG,  REG_READING_MIN,  16'd0,     1'b0, 16'sd0,    1'b0},
    '{ROW_REG,  REG_READING_MAX,  16'd65535, 1'b0, 16'sd0,    1'b0},
    '{ROW_REG,  REG_VALUE_MIN,    16'h8000,  1'b0, 16'sd0,    1'b0},
    '{ROW_REG,  REG_VALUE_MAX,    16'h7FFF,  1'b0, 16'sd0,    1'b0},
    '{ROW_REG,  REG_BAND_LOW,     16'h8000,  1'b0, 16'sd0,    1'b0},
    '{ROW_REG,  REG_BAND_HIGH,    16'h7FFF,  1'b0, 16'sd0,    1'b0},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd65535, 1'b1, 16'sh7FFF, 1'b1},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd0,     1'b1, 16'sh7FFF, 1'b0},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd1,     1'b0, 16'sd0,    1'b0},
    '{ROW_REG,  REG_MODE,         16'd2,     1'b0, 16'sd0,    1'b0},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd65535, 1'b1, 16'sh8000, 1'b1},
    '{ROW_REG,  REG_MODE,         16'd0,     1'b0, 16'sd0,    1'b0},
    '{ROW_REG,  REG_SAMPLE_COUNT, 16'd0,     1'b0, 16'sd0,    1'b0}, // count zero
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd40000, 1'b0, 16'sd0,    1'b0},
    '{ROW_REG,  REG_SAMPLE_COUNT, 16'd3,     1'b0, 16'sd0,    1'b0}, // burst of three
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd30000, 1'b0, 16'sd0,    1'b0},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd100,   1'b0, 16'sd0,    1'b0},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd60000, 1'b0, 16'sd0,    1'b0},
    '{ROW_REG,  REG_MODE,         16'd1,     1'b0, 16'sd0,    1'b0}, // interleaved
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd65535, 1'b0, 16'sd0,    1'b0},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd2,     1'b0, 16'sd0,    1'b0},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd32768, 1'b0, 16'sd0,    1'b0},
    '{ROW_ECHO, REG_SAMPLE_COUNT, 16'd12345, 1'b0, 16'sd0,    1'b0}
  };

  logic clk;
  logic rst_n;

  ers_in_if  in_if ();
  ers_out_if out_if ();
  ers_cfg_if cfg_if ();

  echo_range_median_scaler_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Register copy
  logic [CNT_CFG_W-1:0]     run_cfg;
  logic [MODE_W-1:0]        mode_cfg;
  logic [DATA_W-1:0]        rd_lo;
  logic [DATA_W-1:0]        rd_hi;
  logic signed [DATA_W-1:0] val_lo;
  logic signed [DATA_W-1:0] val_hi;
  logic signed [DATA_W-1:0] band_lo;
  logic signed [DATA_W-1:0] band_hi;

  // Filter state copy
  logic signed [DATA_W-1:0] reading_store [DEPTH];
  int unsigned              fill;
  logic signed [DATA_W-1:0] prev_value;

  scaled_res_t expected_q [$];
  int          errors;
  int          items_sent;
  bit          idle_en;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic mirror_reset();
    run_cfg    = RST_SAMPLE_COUNT;
    mode_cfg   = RST_MODE;
    rd_lo      = RST_READING_MIN;
    rd_hi      = RST_READING_MAX;
    val_lo     = RST_VALUE_MIN;
    val_hi     = RST_VALUE_MAX;
    band_lo    = RST_BAND_LOW;
    band_hi    = RST_BAND_HIGH;
    fill       = 0;
    prev_value = RST_LAST_VALUE;
  endtask

  task automatic mirror_write(input reg_idx_t idx, input logic [DATA_W-1:0] d);
    case (idx)
      REG_SAMPLE_COUNT: run_cfg  = d[CNT_CFG_W-1:0];
      REG_MODE:         mode_cfg = d[MODE_W-1:0];
      REG_READING_MIN:  rd_lo    = d;
      REG_READING_MAX:  rd_hi    = d;
      REG_VALUE_MIN:    val_lo   = d;
      REG_VALUE_MAX:    val_hi   = d;
      REG_BAND_LOW:     band_lo  = d;
      REG_BAND_HIGH:    band_hi  = d;
      default: ;
    endcase
  endtask

  // Clamp and map one width exactly, truncating toward zero
  function automatic logic signed [DATA_W-1:0] scale_echo(input logic [DATA_W-1:0] w);
    longint lo;
    longint hi;
    longint c;
    longint den;
    longint num;
    longint total;
    lo = longint'(rd_lo);
    hi = longint'(rd_hi);
    c  = (w == 0) ? hi : longint'(w);
    if (c < lo)
      c = lo;
    else if (c > hi)
      c = hi;
    den = hi - lo;
    if (den == 0)
      return mode_cfg[MODE_BIT_INV] ? val_hi : val_lo;
    num = (c - lo) * (longint'(val_hi) - longint'(val_lo));
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (mode_cfg[MODE_BIT_INV])
      total = longint'(val_hi) * den - num;
    else
      total = longint'(val_lo) * den + num;
    return DATA_W'(total / den);
  endfunction

  // Element n/2 of the first n stored samples in ascending order
  function automatic logic signed [DATA_W-1:0] upper_median_of(input int unsigned n);
    logic signed [DATA_W-1:0] sorted [DEPTH];
    logic signed [DATA_W-1:0] key;
    int j;
    for (int i = 0; i < n; i++)
      sorted[i] = reading_store[i];
    for (int i = 1; i < n; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    return sorted[n/2];
  endfunction

  // Advance the filter copy by one request and work out its result, if any
  task automatic predict_echo(input logic [DATA_W-1:0] w, output bit produced,
                              output scaled_res_t res);
    int unsigned run;
    logic signed [DATA_W-1:0] v;
    produced = 1'b0;
    res = '0;
    run = (run_cfg > DEPTH) ? DEPTH : run_cfg;
    if (run <= 1) begin
      v = scale_echo(w);
    end else if (mode_cfg[MODE_BIT_ILV]) begin
      if (fill < run) begin
        reading_store[fill] = scale_echo(w);
        fill++;
        return;
      end
      v = upper_median_of(fill);
      fill = 0;
    end else begin
      if (fill >= run)
        fill = 0;
      reading_store[fill] = scale_echo(w);
      fill++;
      if (fill < run)
        return;
      v = upper_median_of(run);
      fill = 0;
    end
    produced = 1'b1;
    res.value = v;
    res.changed = (v != prev_value) && (v >= band_lo) && (v <= band_hi);
    prev_value = v;
  endtask

  task automatic send_echo(input logic [DATA_W-1:0] w, input bit typed,
                           input scaled_res_t typed_res);
    bit produced;
    scaled_res_t res;
    // hold off for a burst, now and then a run of bursts
    if (idle_en && $urandom_range(0, 9) < 3) begin
      in_if.valid <= 1'b0;
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(2, 10) : 1)
        repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.echo_width <= w;
    do @(posedge clk); while (!in_if.ready);
    predict_echo(w, produced, res);
    if (produced)
      expected_q.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  // Drop the request line, drain all results and let store-only work finish
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    mirror_write(idx, d);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Draw a register setting, extremes included, and write all or part of it
  task automatic pick_setup(input bit every_reg);
    logic [DATA_W-1:0] vals [8];
    int a;
    int b;
    case ($urandom_range(0, 19))
      0:       vals[REG_SAMPLE_COUNT] = 16'd0;
      1:       vals[REG_SAMPLE_COUNT] = 16'd1;
      2:       vals[REG_SAMPLE_COUNT] = 16'd16;
      3:       vals[REG_SAMPLE_COUNT] = 16'd17;
      4:       vals[REG_SAMPLE_COUNT] = 16'd31;
      default: vals[REG_SAMPLE_COUNT] = 16'($urandom_range(2, 6));
    endcase
    vals[REG_MODE] = 16'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: begin
        a = $urandom_range(0, 65535);
        b = a;
      end
      1: begin
        a = $urandom_range(1, 65535);
        b = $urandom_range(0, a - 1);
      end
      2: begin
        a = 0;
        b = 65535;
      end
      3: begin
        a = $urandom_range(0, 65535);
        b = $urandom_range(0, 65535);
      end
      default: begin
        a = $urandom_range(0, 30000);
        b = a + $urandom_range(1, 35535);
      end
    endcase
    vals[REG_READING_MIN] = DATA_W'(a);
    vals[REG_READING_MAX] = DATA_W'(b);
    case ($urandom_range(0, 3))
      0: begin
        a = $urandom_range(0, 1) ? -32768 : 32767;
        b = (a < 0) ? 32767 : -32768;
      end
      1: begin
        a = int'($urandom_range(0, 65535)) - 32768;
        b = int'($urandom_range(0, 65535)) - 32768;
      end
      default: begin
        a = int'($urandom_range(0, 200)) - 100;
        b = int'($urandom_range(0, 200)) - 100;
      end
    endcase
    vals[REG_VALUE_MIN] = DATA_W'(a);
    vals[REG_VALUE_MAX] = DATA_W'(b);
    case ($urandom_range(0, 3))
      0: begin
        vals[REG_BAND_LOW]  = 16'h8000;
        vals[REG_BAND_HIGH] = 16'h7FFF;
      end
      1: begin
        vals[REG_BAND_LOW]  = 16'($urandom_range(0, 65535));
        vals[REG_BAND_HIGH] = 16'($urandom_range(0, 65535));
      end
      default: begin
        // band around the value range, a little wider or narrower
        vals[REG_BAND_LOW]  = DATA_W'(((a < b) ? a : b) + int'($urandom_range(0, 20)) - 10);
        vals[REG_BAND_HIGH] = DATA_W'(((a < b) ? b : a) + int'($urandom_range(0, 20)) - 10);
      end
    endcase
    for (int i = 0; i < 8; i++)
      if (every_reg || $urandom_range(0, 1))
        write_reg(reg_idx_t'(i), vals[i]);
  endtask

  function automatic logic [DATA_W-1:0] pick_echo();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return rd_lo;
      2:       return rd_hi;
      3:       return 16'($urandom_range(0, 65535));
      4:       return rd_lo + 16'($urandom_range(0, 2)) - 16'd1;
      5:       return rd_hi + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom_range(rd_lo, rd_hi));
    endcase
  endfunction

  // Stimulus
  initial begin
    int batch;
    bit every_reg;
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.echo_width <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= REG_SAMPLE_COUNT;
    cfg_if.data      <= '0;
    errors     = 0;
    items_sent = 0;
    idle_en    = 1'b1;
    every_reg  = 1'b1;
    mirror_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        send_echo(DIRECTED[i].data, DIRECTED[i].typed,
                  scaled_res_t'{DIRECTED[i].exp_value, DIRECTED[i].exp_changed});
      end
    end

    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      pick_setup(every_reg);
      every_reg = 1'b0;
      batch = $urandom_range(10, 60);
      repeat (batch) begin
        if (items_sent >= ITEM_TARGET - CALM_TAIL)
          idle_en = 1'b0;
        send_echo(pick_echo(), 1'b0, '0);
        // now and then hold requests until every result is back
        if ($urandom_range(0, 99) == 0) begin
          in_if.valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
    end

    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Result side stalls
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (idle_en && $urandom_range(0, 9) < 2) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    scaled_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        note_mismatch("unexpected result, value", out_if.scaled_value, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_if.scaled_value !== want.value)
          note_mismatch("scaled_value", out_if.scaled_value, want.value);
        if (out_if.value_changed !== want.changed)
          note_mismatch("value_changed", out_if.value_changed, want.changed);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
